@@ sv/http_status_line_parser_assert.svh @@
// Assertion macros for the HTTP status line parser checker.
// Depends on nothing; included by the checker file.
`ifndef HTTP_STATUS_LINE_PARSER_ASSERT_SVH
`define HTTP_STATUS_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HSP_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("hsp assertion failed");

// Next-cycle implication, disabled during reset
`define HSP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("hsp assertion failed");

`endif

@@ sv/hsp_pkg.sv @@
// Shared types and constants of the HTTP status line parser.
// No dependencies; used by every RTL file.
package hsp_pkg;

   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 10;
   localparam int POS_W       = 3;
   localparam int PREFIX_LEN  = 5;
   localparam int CODE_DIGITS = 3;

   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

   localparam logic [CODE_W-1:0] CODE_MIN = 10'd100;
   localparam logic [CODE_W-1:0] CODE_MAX = 10'd999;

   // One received byte held in the input register
   typedef struct packed {
      logic              start;
      logic [BYTE_W-1:0] data;
   } hsp_item_type;

   // Result produced by the parser core for one byte
   typedef struct packed {
      logic              valid;
      logic              ok;
      logic [CODE_W-1:0] code;
   } hsp_result_type;

   // Expected byte of the "HTTP/" prefix at a given position
   function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] ch;
      case (pos)
         3'd0:    ch = 8'h48;   // H
         3'd1:    ch = 8'h54;   // T
         3'd2:    ch = 8'h54;   // T
         3'd3:    ch = 8'h50;   // P
         3'd4:    ch = 8'h2F;   // /
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ sv/hsp_if.sv @@
// Valid/ready channel interfaces for the request bytes and the parse results.
// Depends on hsp_pkg for field widths.
interface hsp_req_if;
   logic                       valid;
   logic                       ready;
   logic                       start_of_response;
   logic [hsp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output start_of_response, output rx_byte, input ready);
   modport sink   (input valid, input start_of_response, input rx_byte, output ready);
endinterface

interface hsp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       status_ok;
   logic [hsp_pkg::CODE_W-1:0] status_code;

   modport source (output valid, output status_ok, output status_code, input ready);
   modport sink   (input valid, input status_ok, input status_code, output ready);
endinterface

@@ sv/http_status_line_parser.sv @@
// The parser takes one response byte per clock cycle, back to back, with no
// idle cycles between bytes as long as results are taken promptly. A
// transferred byte is held in the input register while the core parses it
// against the line state. The line state, and the result register for the
// terminating LF, load when the byte moves on, so the LF is registered in
// the input register and then in the result register, which drives
// rsp.valid. The single state update per byte sets this one-byte-per-cycle
// rate. A result waiting in the result register stalls the input: the held
// byte does not advance until that result is transferred, whether or not the
// byte ends a line. The input register can still take one byte while it is
// empty. req.ready follows rsp.ready in the same cycle.
//
// Top level of the HTTP status line parser.
// Depends on hsp_pkg, hsp_if, hsp_in_stage and hsp_core.
module http_status_line_parser (
   input  logic      clock,
   input  logic      reset,
   hsp_req_if.sink   req,
   hsp_rsp_if.source rsp
);
   import hsp_pkg::*;

   logic              item_valid;
   hsp_item_type      item;
   hsp_result_type    result;
   logic              advance;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;

   // Move the held byte on when the result register can take a result
   assign advance = item_valid && (!rsp_valid_ff || rsp.ready);

   hsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_start  (req.start_of_response),
      .req_data   (req.rx_byte),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   // Load a new result, drop a transferred one, hold otherwise
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_code_in  = rsp_code_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = result.ok;
         rsp_code_in  = result.code;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff   <= rsp_ok_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status_ok   = rsp_ok_ff;
   assign rsp.status_code = rsp_code_ff;

endmodule

@@ sv/hsp_in_stage.sv @@
// Input register of the status line parser: holds one accepted byte.
// Depends on hsp_pkg.
module hsp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_start,
   input  logic [hsp_pkg::BYTE_W-1:0] req_data,
   input  logic                  advance,
   output logic                  item_valid,
   output hsp_pkg::hsp_item_type item
);
   import hsp_pkg::*;

   logic         valid_ff, valid_in;
   hsp_item_type item_ff, item_in;

   // Take a new byte whenever the register is empty or moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = '{start: req_start, data: req_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/hsp_core.sv @@
// Parser core: status line state and the per-byte next-state logic.
// Depends on hsp_pkg.
module hsp_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  hsp_pkg::hsp_item_type   item,
   output hsp_pkg::hsp_result_type result
);
   import hsp_pkg::*;

   typedef enum logic [5:0] {
      PH_PREFIX  = 6'b000001,
      PH_VERSION = 6'b000010,
      PH_CODE    = 6'b000100,
      PH_REASON  = 6'b001000,
      PH_FAILED  = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic              pending_cr_ff, pending_cr_in;

   phase_type         cur_phase;
   logic [POS_W-1:0]  cur_pos;
   logic [CODE_W-1:0] cur_acc;
   logic              cur_pending_cr;
   logic [CODE_W-1:0] acc_times10;
   logic              is_digit;
   logic              line_ok;

   // Start flag clears the state before the byte is parsed
   always_comb begin
      if (item.start) begin
         cur_phase      = PH_PREFIX;
         cur_pos        = '0;
         cur_acc        = '0;
         cur_pending_cr = 1'b0;
      end else begin
         cur_phase      = phase_ff;
         cur_pos        = pos_ff;
         cur_acc        = acc_ff;
         cur_pending_cr = pending_cr_ff;
      end
   end

   assign acc_times10 = (cur_acc << 3) + (cur_acc << 1);
   assign is_digit    = item.data inside {[CH_ZERO:CH_NINE]};
   assign line_ok     = (cur_phase == PH_REASON) ||
                        (cur_phase == PH_CODE && cur_pos == POS_W'(CODE_DIGITS));

   // Advance the parse by one byte
   always_comb begin
      phase_in      = cur_phase;
      pos_in        = cur_pos;
      acc_in        = cur_acc;
      pending_cr_in = cur_pending_cr;
      result        = '{valid: 1'b0, ok: 1'b0, code: '0};

      if (cur_phase == PH_DONE) begin
         // ignore bytes until the next start flag
      end else if (item.data == CH_LF) begin
         phase_in     = PH_DONE;
         result.valid = 1'b1;
         if (line_ok && cur_acc >= CODE_MIN && cur_acc <= CODE_MAX) begin
            result.ok   = 1'b1;
            result.code = cur_acc;
         end
      end else begin
         case (cur_phase)
            PH_PREFIX: begin
               if (cur_pos < POS_W'(PREFIX_LEN) && item.data == prefix_char(cur_pos)) begin
                  if (cur_pos == POS_W'(PREFIX_LEN - 1)) begin
                     phase_in = PH_VERSION;
                     pos_in   = '0;
                  end else begin
                     pos_in = cur_pos + 1'b1;
                  end
               end else begin
                  phase_in = PH_FAILED;
               end
            end
            PH_VERSION: begin
               if (item.data == CH_SP) begin
                  phase_in      = PH_CODE;
                  pos_in        = '0;
                  acc_in        = '0;
                  pending_cr_in = 1'b0;
               end
            end
            PH_CODE: begin
               if (cur_pending_cr) begin
                  // the CR was not followed by LF: malformed code
                  phase_in      = PH_FAILED;
                  pending_cr_in = 1'b0;
               end else if (item.data == CH_CR) begin
                  pending_cr_in = 1'b1;
               end else if (item.data == CH_SP) begin
                  phase_in = (cur_pos == POS_W'(CODE_DIGITS)) ? PH_REASON : PH_FAILED;
               end else if (is_digit && cur_pos < POS_W'(CODE_DIGITS)) begin
                  acc_in = acc_times10 + {{(CODE_W-4){1'b0}}, item.data[3:0]};
                  pos_in = cur_pos + 1'b1;
               end else begin
                  phase_in = PH_FAILED;
               end
            end
            default: begin
               // reason and failed: wait for the LF
            end
         endcase
      end

      if (!step) begin
         result.valid = 1'b0;
      end
   end

   // Hold state unless a byte is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         pos_ff        <= '0;
         acc_ff        <= '0;
         pending_cr_ff <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         pending_cr_ff <= pending_cr_in;
      end
   end

endmodule

@@ sv/hsp_checker.sv @@
// Port-level checker for the HTTP status line parser, bound to the top level.
// Depends on hsp_pkg and http_status_line_parser_assert.svh.
`include "http_status_line_parser_assert.svh"

module hsp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_status_ok,
   input logic [hsp_pkg::CODE_W-1:0] rsp_status_code
);
   import hsp_pkg::*;

   // A stalled result holds its payload
   `HSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status_ok) && $stable(rsp_status_code))

   // A malformed line reports code zero
   `HSP_ASSERT_IMP(a_bad_code_zero, clock, reset, rsp_valid && !rsp_status_ok,
      rsp_status_code == '0)

   // A good line carries a three-digit code
   `HSP_ASSERT_IMP(a_ok_code_range, clock, reset, rsp_valid && rsp_status_ok,
      rsp_status_code >= CODE_MIN && rsp_status_code <= CODE_MAX)

   // With no result waiting, input is never stalled
   `HSP_ASSERT_IMP(a_ready_when_idle, clock, reset, !rsp_valid && req_valid, req_ready)

endmodule

bind http_status_line_parser hsp_checker u_hsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status_ok   (rsp.status_ok),
   .rsp_status_code (rsp.status_code)
);
